>>> design/first_fit_block_allocator_unit_macros.svh
// Assertion macros used by the allocator's top-level RTL file.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FFBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ffba_pkg.sv
// Types and constants of the first-fit block allocator.
// Depends on nothing; used by ffba_cell and first_fit_block_allocator_unit.
`timescale 1ns / 1ps

package ffba_pkg;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic REG_HEAP_BASE  = 1'b0;
	localparam logic REG_HEAP_BYTES = 1'b1;

	localparam logic [31:0] HEAP_BASE_RST  = 32'h0000_0000;
	localparam logic [31:0] HEAP_BYTES_RST = 32'h0001_0000;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_FIT       = 3'd1,
		ST_TABLE_FULL   = 3'd2,
		ST_NOT_FOUND    = 3'd3,
		ST_ALREADY_FREE = 3'd4
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] request_size;
		logic [31:0] free_address;
	} in_item_t;

	typedef struct packed {
		logic [31:0] block_address;
		status_t     status;
		logic        single_block;
	} out_item_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
		logic        used;
	} entry_t;

	typedef struct packed {
		logic        kind;
		logic [32:0] need;
		logic [31:0] address;
	} query_t;

	typedef enum logic [3:0] {
		OP_HOLD     = 4'd0,
		OP_INIT     = 4'd1,
		OP_SET_USED = 4'd2,
		OP_SPLIT    = 4'd3,
		OP_SHIFT_R  = 4'd4,
		OP_SHIFT_L1 = 4'd5,
		OP_SHIFT_L2 = 4'd6,
		OP_FREE     = 4'd7,
		OP_MERGE1   = 4'd8,
		OP_MERGE2   = 4'd9
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [31:0] size;
		logic [32:0] need;
	} cell_ctrl_t;

endpackage

>>> design/first_fit_block_allocator_unit.sv
// First-fit heap allocator with coalescing, built as a row of MAX_BLOCKS cells in address
// order. In the cycle a request is accepted every cell compares its block with the
// request at once, and in the next cycle the cells split, mark, merge or shift by one or
// two places; the result beat then sits in the output register. No new request is taken
// while an update runs or while a result beat is stalled at the output.
// Writing heap_base or heap_bytes restarts the heap as one free block; there is no clearing
// pass. Depends on ffba_pkg, ffba_cell and first_fit_block_allocator_unit_macros.svh.
`timescale 1ns / 1ps
`include "first_fit_block_allocator_unit_macros.svh"

module first_fit_block_allocator_unit #(
	parameter int unsigned MAX_BLOCKS   = 64,
	parameter int unsigned HEADER_BYTES = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ffba_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ffba_pkg::out_item_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_UPDATE = 2'b10
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [31:0]             heap_base_q;
	logic [31:0]             heap_bytes_q;
	logic                    kind_s1;
	logic [31:0]             size_s1;
	logic [32:0]             need_s1;
	logic [MAX_BLOCKS-1:0]   hits_s1;
	logic                    out_valid_q;
	ffba_pkg::out_item_t     out_data_q;

	logic                    cfg_we;
	logic                    in_accept;
	ffba_pkg::query_t        query;
	ffba_pkg::entry_t        init_entry;
	ffba_pkg::entry_t        entry_w [MAX_BLOCKS];
	ffba_pkg::entry_t        ent_pad [MAX_BLOCKS+3];
	ffba_pkg::cell_ctrl_t    ctrl_v [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0]   hit_v;
	logic [MAX_BLOCKS-1:0]   valid_v;
	logic [MAX_BLOCKS-1:0]   used_v;
	logic [MAX_BLOCKS-1:0]   low_mask;
	logic [MAX_BLOCKS-1:0]   first_hit;
	logic [MAX_BLOCKS-1:0]   after_hit;
	logic [MAX_BLOCKS+2:0]   first_pad;
	logic [MAX_BLOCKS+2:0]   after_pad;
	logic                    any_hit;
	logic                    used_at_hit;
	logic                    next_free;
	logic                    prev_free;
	logic                    table_full;
	logic                    alloc_ok;
	logic                    free_ok;
	logic [31:0]             hit_start;
	logic [CW-1:0]           count_d;
	ffba_pkg::status_t       status_d;

	assign pready    = 1'b1;
	assign cfg_we    = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == ffba_pkg::REG_HEAP_BYTES) ? heap_bytes_q : heap_base_q;
	assign in_stall  = (state_q == ST_UPDATE) || (out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign query.kind    = in_data.kind;
	assign query.need    = {1'b0, in_data.request_size} + 33'(HEADER_BYTES);
	assign query.address = in_data.free_address;

	assign init_entry.start  = (paddr[2] == ffba_pkg::REG_HEAP_BASE) ? pwdata : heap_base_q;
	assign init_entry.length = (paddr[2] == ffba_pkg::REG_HEAP_BYTES) ? pwdata : heap_bytes_q;
	assign init_entry.used   = 1'b0;

	assign ent_pad[0]            = '0;
	assign ent_pad[MAX_BLOCKS+1] = '0;
	assign ent_pad[MAX_BLOCKS+2] = '0;

	for (genvar gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
		assign ent_pad[gi+1] = entry_w[gi];
		assign valid_v[gi]   = (CW'(gi) < count_q);
		assign used_v[gi]    = entry_w[gi].used;

		ffba_cell #(
			.HEADER_BYTES(HEADER_BYTES)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl_v[gi]),
			.query (query),
			.valid (valid_v[gi]),
			.init  (init_entry),
			.left  (ent_pad[gi]),
			.right1(ent_pad[gi+2]),
			.right2(ent_pad[gi+3]),
			.entry (entry_w[gi]),
			.hit   (hit_v[gi])
		);
	end

	assign low_mask  = hits_s1 ^ (hits_s1 - MAX_BLOCKS'(1));
	assign first_hit = low_mask & hits_s1;
	assign after_hit = ~low_mask;
	assign any_hit   = |hits_s1;
	assign first_pad = {2'b00, first_hit, 1'b0};
	assign after_pad = {2'b00, after_hit, 1'b0};

	assign used_at_hit = |(first_hit & used_v);
	assign next_free   = |((first_hit << 1) & ~used_v & valid_v);
	assign prev_free   = |((first_hit >> 1) & ~used_v);
	assign table_full  = (count_q == CW'(MAX_BLOCKS));

	assign alloc_ok = (kind_s1 == ffba_pkg::KIND_ALLOC) && any_hit && !table_full;
	assign free_ok  = (kind_s1 == ffba_pkg::KIND_FREE) && any_hit && used_at_hit;

	always_comb begin
		hit_start = '0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			hit_start = hit_start | (first_hit[i] ? entry_w[i].start : 32'd0);
		end
	end

	always_comb begin
		if (kind_s1 == ffba_pkg::KIND_ALLOC) begin
			if (!any_hit) begin
				status_d = ffba_pkg::ST_NO_FIT;
			end else if (table_full) begin
				status_d = ffba_pkg::ST_TABLE_FULL;
			end else begin
				status_d = ffba_pkg::ST_OK;
			end
		end else begin
			if (!any_hit) begin
				status_d = ffba_pkg::ST_NOT_FOUND;
			end else if (!used_at_hit) begin
				status_d = ffba_pkg::ST_ALREADY_FREE;
			end else begin
				status_d = ffba_pkg::ST_OK;
			end
		end
	end

	always_comb begin
		if (alloc_ok) begin
			count_d = count_q + CW'(1);
		end else if (free_ok) begin
			count_d = count_q - CW'(prev_free) - CW'(next_free);
		end else begin
			count_d = count_q;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			ctrl_v[i].size = size_s1;
			ctrl_v[i].need = need_s1;
			ctrl_v[i].op   = ffba_pkg::OP_HOLD;
			if (cfg_we) begin
				if (i == 0) begin
					ctrl_v[i].op = ffba_pkg::OP_INIT;
				end
			end else if ((state_q == ST_UPDATE) && alloc_ok) begin
				if (first_pad[i+1]) begin
					ctrl_v[i].op = ffba_pkg::OP_SET_USED;
				end else if (first_pad[i]) begin
					ctrl_v[i].op = ffba_pkg::OP_SPLIT;
				end else if (after_pad[i]) begin
					ctrl_v[i].op = ffba_pkg::OP_SHIFT_R;
				end
			end else if ((state_q == ST_UPDATE) && free_ok) begin
				if (!prev_free && !next_free) begin
					if (first_pad[i+1]) begin
						ctrl_v[i].op = ffba_pkg::OP_FREE;
					end
				end else if (!prev_free) begin
					if (first_pad[i+1]) begin
						ctrl_v[i].op = ffba_pkg::OP_MERGE1;
					end else if (after_pad[i+1]) begin
						ctrl_v[i].op = ffba_pkg::OP_SHIFT_L1;
					end
				end else if (!next_free) begin
					if (first_pad[i+2]) begin
						ctrl_v[i].op = ffba_pkg::OP_MERGE1;
					end else if (first_pad[i+1] || after_pad[i+1]) begin
						ctrl_v[i].op = ffba_pkg::OP_SHIFT_L1;
					end
				end else begin
					if (first_pad[i+2]) begin
						ctrl_v[i].op = ffba_pkg::OP_MERGE2;
					end else if (first_pad[i+1] || after_pad[i+1]) begin
						ctrl_v[i].op = ffba_pkg::OP_SHIFT_L2;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= CW'(1);
			heap_base_q  <= ffba_pkg::HEAP_BASE_RST;
			heap_bytes_q <= ffba_pkg::HEAP_BYTES_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (paddr[2] == ffba_pkg::REG_HEAP_BASE) begin
					heap_base_q <= pwdata;
				end else begin
					heap_bytes_q <= pwdata;
				end
				count_q <= CW'(1);
			end else if (state_q == ST_UPDATE) begin
				count_q <= count_d;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (state_q == ST_UPDATE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1 <= in_data.kind;
			size_s1 <= in_data.request_size;
			need_s1 <= query.need;
			hits_s1 <= hit_v;
		end
		if (state_q == ST_UPDATE) begin
			out_data_q.block_address <= alloc_ok ? hit_start : 32'd0;
			out_data_q.status        <= status_d;
			out_data_q.single_block  <= (count_d == CW'(1));
		end
	end

	`FFBA_ASSERT_NEXT(a_accept_starts_update, clk, arst_n, in_accept, state_q == ST_UPDATE, "accepted beat did not start an update")
	`FFBA_ASSERT_NEXT(a_update_gives_result, clk, arst_n, state_q == ST_UPDATE, out_valid_q, "update did not load a result beat")
	`FFBA_ASSERT_NOW(a_first_hit_single, clk, arst_n, state_q == ST_UPDATE, $onehot0(first_hit), "more than one cell selected")
	`FFBA_ASSERT_NEXT(a_alloc_adds_block, clk, arst_n, (state_q == ST_UPDATE) && alloc_ok && !cfg_we, count_q == $past(count_q) + CW'(1), "allocation did not add one block")
	`FFBA_ASSERT_NOW(a_count_in_range, clk, arst_n, 1'b1, (count_q != '0) && (count_q <= CW'(MAX_BLOCKS)), "block count out of range")

endmodule

>>> design/ffba_cell.sv
// One table cell: holds a block's start, length and used flag, matches a query
// and takes its next contents from itself, its neighbours or the init entry. Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_cell #(
	parameter int unsigned HEADER_BYTES = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffba_pkg::cell_ctrl_t ctrl,
	input  ffba_pkg::query_t    query,
	input  logic                valid,
	input  ffba_pkg::entry_t    init,
	input  ffba_pkg::entry_t    left,
	input  ffba_pkg::entry_t    right1,
	input  ffba_pkg::entry_t    right2,
	output ffba_pkg::entry_t    entry,
	output logic                hit
);

	localparam logic [31:0] HDR  = 32'(HEADER_BYTES);
	localparam logic [31:0] HDR2 = 32'(2 * HEADER_BYTES);

	ffba_pkg::entry_t entry_q;

	assign entry = entry_q;

	always_comb begin
		if (query.kind == ffba_pkg::KIND_FREE) begin
			hit = valid && (entry_q.start == query.address);
		end else begin
			hit = valid && !entry_q.used && ({1'b0, entry_q.length} >= query.need);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.start  <= ffba_pkg::HEAP_BASE_RST;
			entry_q.length <= ffba_pkg::HEAP_BYTES_RST;
			entry_q.used   <= 1'b0;
		end else begin
			case (ctrl.op)
				ffba_pkg::OP_HOLD: begin
					entry_q <= entry_q;
				end
				ffba_pkg::OP_INIT: begin
					entry_q <= init;
				end
				ffba_pkg::OP_SET_USED: begin
					entry_q.length <= ctrl.size;
					entry_q.used   <= 1'b1;
				end
				ffba_pkg::OP_SPLIT: begin
					entry_q.start  <= left.start + ctrl.need[31:0];
					entry_q.length <= left.length - ctrl.need[31:0];
					entry_q.used   <= 1'b0;
				end
				ffba_pkg::OP_SHIFT_R: begin
					entry_q <= left;
				end
				ffba_pkg::OP_SHIFT_L1: begin
					entry_q <= right1;
				end
				ffba_pkg::OP_SHIFT_L2: begin
					entry_q <= right2;
				end
				ffba_pkg::OP_FREE: begin
					entry_q.used <= 1'b0;
				end
				ffba_pkg::OP_MERGE1: begin
					entry_q.length <= entry_q.length + right1.length + HDR;
					entry_q.used   <= 1'b0;
				end
				ffba_pkg::OP_MERGE2: begin
					entry_q.length <= entry_q.length + right1.length + right2.length + HDR2;
					entry_q.used   <= 1'b0;
				end
				default: begin
					entry_q <= entry_q;
				end
			endcase
		end
	end

endmodule
